@@ design/ips_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ips_pkg;

	localparam int unsigned PIX_W   = 16;
	localparam int unsigned LVL_W   = 16;
	localparam int unsigned CNT_W   = 25;
	localparam int unsigned SUM_W   = 40;
	localparam int unsigned SQ_W    = 56;
	localparam int unsigned MEAN_W  = 24;
	localparam int unsigned STD_W   = 24;

	localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(16777216);
	localparam logic [LVL_W-1:0] LEVEL_RESET = LVL_W'(65530);
	localparam logic [PIX_W-1:0] MIN_RESET = PIX_W'(65535);

	// digit multiplier: a operand in two digits, b operand in two digits
	localparam int unsigned MUL_A_W  = SQ_W;
	localparam int unsigned MUL_B_W  = SUM_W;
	localparam int unsigned A_DIG_W  = MUL_A_W / 2;
	localparam int unsigned B_DIG_W  = MUL_B_W / 2;
	localparam int unsigned PP_W     = A_DIG_W + B_DIG_W;
	localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
	localparam int unsigned MUL_STEPS = 4;
	localparam int unsigned MSTEP_W  = 3;

	// n * sum of squares and sum * sum both fit in P_W bits
	localparam int unsigned P_W      = 81;
	localparam int unsigned DIFF_W   = P_W + 1;
	localparam int unsigned NN_W     = 2 * CNT_W - 1;

	localparam int unsigned MEAN_FRAC = 8;
	localparam int unsigned VAR_FRAC  = 16;

	localparam int unsigned DVD_W     = P_W + VAR_FRAC;
	localparam int unsigned DVS_W     = NN_W;
	localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

	localparam int unsigned RAD_W     = 2 * STD_W;
	localparam int unsigned ROOT_W    = STD_W;
	localparam int unsigned SQRT_CNT_W = $clog2(ROOT_W);

	typedef enum logic [3:0] {
		S_ACCUM,
		S_MUL_NSQ,
		S_MUL_SS,
		S_DIFF,
		S_ABS,
		S_MUL_NN,
		S_DIV_MEAN,
		S_DIV_VAR,
		S_SQRT,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		MSEL_N_SQ,
		MSEL_SUM_SUM,
		MSEL_N_N
	} mul_sel_t;

	typedef enum logic {
		DSEL_MEAN,
		DSEL_VAR
	} div_sel_t;

	typedef struct packed {
		logic     take;
		logic     accum_en;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     p1_load;
		logic     diff_load;
		logic     abs_en;
		logic     nn_load;
		logic     div_start;
		div_sel_t div_sel;
		logic     mean_load;
		logic     sqrt_start;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic mul_done;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

@@ design/ips_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ips_pix_if import ips_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             last;

	modport source (output valid, output pixel, output last, input ready);
	modport sink (input valid, input pixel, input last, output ready);
endinterface

interface ips_res_if import ips_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  max_value;
	logic [PIX_W-1:0]  min_value;
	logic [MEAN_W-1:0] mean_q8;
	logic [STD_W-1:0]  std_q8;
	logic [CNT_W-1:0]  overload_count;
	logic [CNT_W-1:0]  pixel_count;

	modport source (output valid, output max_value, output min_value, output mean_q8,
		output std_q8, output overload_count, output pixel_count, input ready);
	modport sink (input valid, input max_value, input min_value, input mean_q8,
		input std_q8, input overload_count, input pixel_count, output ready);
endinterface

interface ips_cfg_if import ips_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [LVL_W-1:0] overload_level;

	modport source (output valid, output overload_level, input ready);
	modport sink (input valid, input overload_level, output ready);
endinterface

`default_nettype wire

@@ design/image_pixel_statistics_unit.sv @@
// one pixel per cycle while a frame streams in; the squaring input stage is registered
// ahead of the accumulators; after the last pixel the result is worked out by
// three 5-step digit multiplies, two 97-step divisions and a 24-step square root
// the pixel port takes no new frame until the last result enters the result register
// reset clears the accumulators and the result valid flag, sets the running minimum
// to 65535 and the overload level to 65530; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module image_pixel_statistics_unit import ips_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ips_cfg_if.sink     cfg,
	ips_pix_if.sink     pixels,
	ips_res_if.source   stats
);

	cmd_t    cmd;
	status_t st;
	logic    pix_ready;

	// configuration is taken at any time
	assign cfg.ready    = 1'b1;
	assign pixels.ready = pix_ready;

	ips_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.st        (st),
		.pix_valid (pixels.valid),
		.pix_ready (pix_ready),
		.cmd       (cmd)
	);

	ips_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.pixel          (pixels.pixel),
		.last           (pixels.last),
		.cfg_we         (cfg.valid),
		.cfg_level      (cfg.overload_level),
		.out_ready      (stats.ready),
		.out_valid      (stats.valid),
		.max_value      (stats.max_value),
		.min_value      (stats.min_value),
		.mean_q8        (stats.mean_q8),
		.std_q8         (stats.std_q8),
		.overload_count (stats.overload_count),
		.pixel_count    (stats.pixel_count)
	);

endmodule

`default_nettype wire

@@ design/ips_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ips_div import ips_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DVD_W-1:0]     dq_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVS_W:0]       trial;
	logic [DVS_W:0]       diff;
	logic                 fits;

	// restoring division, one quotient bit per cycle, msb first
	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

`default_nettype wire

@@ design/ips_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ips_sqrt import ips_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]      rad_q;
	logic [ROOT_W:0]       rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [ROOT_W+2:0]     rem_t;
	logic [ROOT_W+2:0]     trial;
	logic [ROOT_W+2:0]     diff;
	logic                  fits;

	// two radicand bits brought down per step, one root bit out
	assign rem_t = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = (ROOT_W + 3)'({root_q, 2'b01});
	assign diff  = rem_t - trial;
	assign fits  = rem_t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQRT_CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? diff[ROOT_W:0] : rem_t[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

@@ design/ips_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ips_datapath import ips_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           st,
	input  logic [PIX_W-1:0]  pixel,
	input  logic              last,
	input  logic              cfg_we,
	input  logic [LVL_W-1:0]  cfg_level,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [PIX_W-1:0]  max_value,
	output logic [PIX_W-1:0]  min_value,
	output logic [MEAN_W-1:0] mean_q8,
	output logic [STD_W-1:0]  std_q8,
	output logic [CNT_W-1:0]  overload_count,
	output logic [CNT_W-1:0]  pixel_count
);

	// input stage
	logic               valid_s1;
	logic               last_s1;
	logic [PIX_W-1:0]   pixel_s1;
	logic [2*PIX_W-1:0] square_s1;

	// accumulators
	logic [LVL_W-1:0] overload_level_q;
	logic [CNT_W-1:0] count_acc_q;
	logic [SUM_W-1:0] sum_acc_q;
	logic [SQ_W-1:0]  square_sum_acc_q;
	logic [PIX_W-1:0] running_max_q;
	logic [PIX_W-1:0] running_min_q;
	logic [CNT_W-1:0] overload_acc_q;

	// digit multiplier
	logic [MUL_A_W-1:0] mul_a_q;
	logic [MUL_B_W-1:0] mul_b_q;
	logic [MSTEP_W-1:0] mul_step_q;
	logic               mul_busy_q;
	logic               mul_done_q;
	logic [PP_W-1:0]    pp_q;
	logic [1:0]         pp_idx_q;
	logic               pp_vld_q;
	logic [PROD_W-1:0]  mul_acc_q;
	logic [A_DIG_W-1:0] a_dig;
	logic [B_DIG_W-1:0] b_dig;
	logic [MUL_A_W-1:0] a_sel;
	logic [MUL_B_W-1:0] b_sel;
	logic [5:0]         pp_shift;

	// finishing arithmetic
	logic [P_W-1:0]    p1_q;
	logic [DIFF_W-1:0] diff_q;
	logic [NN_W-1:0]   nn_q;
	logic [MEAN_W-1:0] mean_q;
	logic [DVD_W-1:0]  div_dividend;
	logic [DVS_W-1:0]  div_divisor;
	logic [DVD_W-1:0]  div_quot;
	logic              div_done;
	logic [ROOT_W-1:0] sqrt_root;
	logic              sqrt_done;
	logic              zero_n;

	logic              out_valid_q;
	logic              keep_pixel;

	assign keep_pixel = cmd.accum_en && valid_s1 && (count_acc_q < MAX_PIXELS);
	assign zero_n     = (count_acc_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pixel_s1  <= pixel;
			last_s1   <= last;
			square_s1 <= pixel * pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overload_level_q <= LEVEL_RESET;
		end else if (cfg_we) begin
			overload_level_q <= cfg_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_acc_q      <= '0;
			sum_acc_q        <= '0;
			square_sum_acc_q <= '0;
			running_max_q    <= '0;
			running_min_q    <= MIN_RESET;
			overload_acc_q   <= '0;
		end else if (cmd.out_load) begin
			count_acc_q      <= '0;
			sum_acc_q        <= '0;
			square_sum_acc_q <= '0;
			running_max_q    <= '0;
			running_min_q    <= MIN_RESET;
			overload_acc_q   <= '0;
		end else if (keep_pixel) begin
			count_acc_q      <= count_acc_q + 1'b1;
			sum_acc_q        <= sum_acc_q + SUM_W'(pixel_s1);
			square_sum_acc_q <= square_sum_acc_q + SQ_W'(square_s1);
			if (pixel_s1 > running_max_q) begin
				running_max_q <= pixel_s1;
			end
			if (pixel_s1 < running_min_q) begin
				running_min_q <= pixel_s1;
			end
			if (pixel_s1 >= overload_level_q) begin
				overload_acc_q <= overload_acc_q + 1'b1;
			end
		end
	end

	// multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MSEL_N_SQ: begin
				a_sel = square_sum_acc_q;
				b_sel = MUL_B_W'(count_acc_q);
			end
			MSEL_SUM_SUM: begin
				a_sel = MUL_A_W'(sum_acc_q);
				b_sel = sum_acc_q;
			end
			MSEL_N_N: begin
				a_sel = MUL_A_W'(count_acc_q);
				b_sel = MUL_B_W'(count_acc_q);
			end
			default: begin
				a_sel = '0;
				b_sel = '0;
			end
		endcase
	end

	assign a_dig = mul_step_q[1] ? mul_a_q[MUL_A_W-1:A_DIG_W] : mul_a_q[A_DIG_W-1:0];
	assign b_dig = mul_step_q[0] ? mul_b_q[MUL_B_W-1:B_DIG_W] : mul_b_q[B_DIG_W-1:0];

	always_comb begin
		case (pp_idx_q)
			2'd0:    pp_shift = 6'd0;
			2'd1:    pp_shift = 6'(B_DIG_W);
			2'd2:    pp_shift = 6'(A_DIG_W);
			2'd3:    pp_shift = 6'(A_DIG_W + B_DIG_W);
			default: pp_shift = 6'd0;
		endcase
	end

	// one partial product per cycle, registered in pp_q before it is added to the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_done_q <= 1'b0;
			mul_step_q <= '0;
			pp_vld_q   <= 1'b0;
		end else begin
			mul_done_q <= 1'b0;
			if (cmd.mul_start) begin
				mul_busy_q <= 1'b1;
				mul_step_q <= '0;
				pp_vld_q   <= 1'b0;
			end else if (mul_busy_q) begin
				mul_step_q <= mul_step_q + 1'b1;
				pp_vld_q   <= (mul_step_q < MSTEP_W'(MUL_STEPS));
				if (mul_step_q == MSTEP_W'(MUL_STEPS)) begin
					mul_busy_q <= 1'b0;
					mul_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_a_q   <= a_sel;
			mul_b_q   <= b_sel;
			mul_acc_q <= '0;
		end else if (mul_busy_q) begin
			pp_q     <= a_dig * b_dig;
			pp_idx_q <= mul_step_q[1:0];
			if (pp_vld_q) begin
				mul_acc_q <= mul_acc_q + (PROD_W'(pp_q) << pp_shift);
			end
		end
	end

	// squared-deviation numerator, n squared and the mean
	always_ff @(posedge clk) begin
		if (cmd.p1_load) begin
			p1_q <= mul_acc_q[P_W-1:0];
		end
		if (cmd.diff_load) begin
			diff_q <= {1'b0, p1_q} - {1'b0, mul_acc_q[P_W-1:0]};
		end else if (cmd.abs_en && diff_q[DIFF_W-1]) begin
			diff_q <= DIFF_W'(0) - diff_q;
		end
		if (cmd.nn_load) begin
			nn_q <= mul_acc_q[NN_W-1:0];
		end
		if (cmd.mean_load) begin
			mean_q <= zero_n ? '0 : div_quot[MEAN_W-1:0];
		end
	end

	always_comb begin
		case (cmd.div_sel)
			DSEL_MEAN: begin
				div_dividend = DVD_W'({sum_acc_q, MEAN_FRAC'(0)});
				div_divisor  = DVS_W'(count_acc_q);
			end
			DSEL_VAR: begin
				div_dividend = {diff_q[P_W-1:0], VAR_FRAC'(0)};
				div_divisor  = nn_q;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
			end
		endcase
	end

	ips_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	ips_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (div_quot[RAD_W-1:0]),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			max_value      <= running_max_q;
			min_value      <= running_min_q;
			mean_q8        <= mean_q;
			std_q8         <= zero_n ? '0 : sqrt_root;
			overload_count <= overload_acc_q;
			pixel_count    <= count_acc_q;
		end
	end

	assign out_valid = out_valid_q;

	assign st.frame_end = valid_s1 && last_s1;
	assign st.mul_done  = mul_done_q;
	assign st.div_done  = div_done;
	assign st.sqrt_done = sqrt_done;
	assign st.out_free  = !out_valid_q || out_ready;

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register loaded over an untaken result");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_acc_q <= MAX_PIXELS)
		else $error("pixel count beyond frame limit");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(count_acc_q != '0) |-> (running_min_q <= running_max_q))
		else $error("running min above running max");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done_q |-> $past(mul_busy_q))
		else $error("multiplier done without a run");

	a_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |-> !cmd.take)
		else $error("pixel taken behind the frame end");

endmodule

`default_nettype wire

@@ design/ips_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ips_ctrl import ips_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t st,
	input  logic    pix_valid,
	output logic    pix_ready,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_next;
	logic   launched_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_ACCUM: begin
				if (st.frame_end) begin
					state_next = S_MUL_NSQ;
				end
			end
			S_MUL_NSQ: begin
				if (st.mul_done) begin
					state_next = S_MUL_SS;
				end
			end
			S_MUL_SS: begin
				if (st.mul_done) begin
					state_next = S_DIFF;
				end
			end
			S_DIFF: begin
				state_next = S_ABS;
			end
			S_ABS: begin
				state_next = S_MUL_NN;
			end
			S_MUL_NN: begin
				if (st.mul_done) begin
					state_next = S_DIV_MEAN;
				end
			end
			S_DIV_MEAN: begin
				if (st.div_done) begin
					state_next = S_DIV_VAR;
				end
			end
			S_DIV_VAR: begin
				if (st.div_done) begin
					state_next = S_SQRT;
				end
			end
			S_SQRT: begin
				if (st.sqrt_done) begin
					state_next = S_OUT;
				end
			end
			S_OUT: begin
				if (st.out_free) begin
					state_next = S_ACCUM;
				end
			end
			default: begin
				state_next = S_ACCUM;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		pix_ready = 1'b0;
		case (state_q)
			S_ACCUM: begin
				// hold off once the frame end sits in the input stage
				pix_ready    = !st.frame_end;
				cmd.take     = pix_valid && !st.frame_end;
				cmd.accum_en = 1'b1;
			end
			S_MUL_NSQ: begin
				cmd.mul_start = !launched_q;
				cmd.mul_sel   = MSEL_N_SQ;
				cmd.p1_load   = st.mul_done;
			end
			S_MUL_SS: begin
				cmd.mul_start = !launched_q;
				cmd.mul_sel   = MSEL_SUM_SUM;
			end
			S_DIFF: begin
				cmd.diff_load = 1'b1;
			end
			S_ABS: begin
				cmd.abs_en = 1'b1;
			end
			S_MUL_NN: begin
				cmd.mul_start = !launched_q;
				cmd.mul_sel   = MSEL_N_N;
				cmd.nn_load   = st.mul_done;
			end
			S_DIV_MEAN: begin
				cmd.div_start = !launched_q;
				cmd.div_sel   = DSEL_MEAN;
				cmd.mean_load = st.div_done;
			end
			S_DIV_VAR: begin
				cmd.div_start = !launched_q;
				cmd.div_sel   = DSEL_VAR;
			end
			S_SQRT: begin
				cmd.sqrt_start = !launched_q;
				cmd.div_sel    = DSEL_VAR;
			end
			S_OUT: begin
				cmd.out_load = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_ACCUM;
			launched_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_next != state_q) begin
				launched_q <= 1'b0;
			end else if (cmd.mul_start || cmd.div_start || cmd.sqrt_start) begin
				launched_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
